@@ src/assert_macros.svh @@
// Assertion helper macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check, also active during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/ffl_pkg.sv @@
// Shared constants and types for the first-fit free-list allocator.
// No dependencies.
`timescale 1ns / 1ps
package ffl_pkg;
  localparam int unsigned MAX_SEG = 1024;
  localparam int unsigned IDX_W = $clog2(MAX_SEG);
  localparam int unsigned CNT_W = $clog2(MAX_SEG + 1);
  localparam int unsigned ENTRY_W = 11;
  localparam int unsigned IN_DATA_W = 64;
  localparam int unsigned IN_USER_W = 2;
  localparam int unsigned OUT_DATA_W = 152;
  localparam logic [31:0] PAGE_ADD = 32'h0000_0fff;
  localparam logic [31:0] PAGE_MASK = 32'hffff_f000;
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE = 1'b1;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] size;
  } seg_t;
endpackage

@@ src/ffl_ram.sv @@
// Generic single-clock RAM, one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module ffl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ src/first_fit_free_list_allocator.sv @@
// First-fit free-list allocator with coalescing, table held in one RAM.
// Depends on ffl_pkg and ffl_ram.
//
// channel  dir  tdata (low bit up)                                 tuser
// s_axis   in   seg_addr, seg_size                                 func, page_round
// m_axis   out  alloc_addr, total_free, entry_count, peak_entries,  free_failed
//               lost_count, lost_bytes, 2 zero bits
//
// One word at a time; each table entry scanned and each entry shifted costs
// a read of the single RAM read port. Scan and shift together cover the
// table at most once.
// Reset clears counters and statistics; the table needs no clearing pass.
// A finished result sits in the output register while the next word is taken.
`timescale 1ns / 1ps
module first_fit_free_list_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ffl_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // seg_addr, seg_size
  input  logic [ffl_pkg::IN_USER_W-1:0]  s_axis_tuser,  // func, page_round
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ffl_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // see table above
  output logic                           m_axis_tuser   // free_failed
);
  import ffl_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_CHK, ST_DEC, ST_DN_RD, ST_DN_WR, ST_UP_RD, ST_UP_WR, ST_DONE
  } state_e;

  state_e            state_q;
  logic              func_q;
  logic [31:0]       addr_q, size_q;
  logic [CNT_W-1:0]  idx_q, k_q, count_q, peak_q;
  seg_t              prev_q, nxt_q;
  logic              has_prev_q, has_next_q;
  logic [31:0]       sum_q, lost_n_q, lost_b_q, got_q;
  logic              failed_q;
  logic              we_q;
  logic [IDX_W-1:0]  waddr_q;
  seg_t              wdata_q;
  logic [IDX_W-1:0]  raddr;
  seg_t              rdata;
  logic [31:0]       in_size;
  logic [CNT_W-1:0]  idx_inc;
  logic              prev_touch, next_touch;

  ffl_ram #(.WIDTH($bits(seg_t)), .DEPTH(MAX_SEG)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we_q),
    .waddr_i(waddr_q),
    .wdata_i(wdata_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_size = s_axis_tuser[1] ? ((s_axis_tdata[63:32] + PAGE_ADD) & PAGE_MASK)
                                   : s_axis_tdata[63:32];
  assign idx_inc = idx_q + CNT_W'(1);
  assign prev_touch = has_prev_q && ((prev_q.addr + prev_q.size) == addr_q);
  assign next_touch = has_next_q && ((addr_q + size_q) == nxt_q.addr);
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    case (state_q)
      ST_DN_RD: raddr = IDX_W'(k_q + CNT_W'(1));
      ST_UP_RD: raddr = IDX_W'(k_q - CNT_W'(1));
      default:  raddr = idx_q[IDX_W-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      peak_q        <= '0;
      sum_q         <= '0;
      lost_n_q      <= '0;
      lost_b_q      <= '0;
      we_q          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      we_q <= 1'b0;
      if (m_axis_tvalid && m_axis_tready && (state_q != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            func_q     <= s_axis_tuser[0];
            addr_q     <= s_axis_tdata[31:0];
            size_q     <= in_size;
            idx_q      <= '0;
            got_q      <= '0;
            failed_q   <= 1'b0;
            has_prev_q <= 1'b0;
            has_next_q <= 1'b0;
            if (count_q == '0) begin
              state_q <= (s_axis_tuser[0] == FUNC_FREE) ? ST_DEC : ST_DONE;
            end else begin
              state_q <= ST_RD;
            end
          end
        end
        ST_RD: state_q <= ST_CHK;
        ST_CHK: begin
          if (func_q == FUNC_ALLOC) begin
            if (rdata.size >= size_q) begin
              got_q <= rdata.addr;
              sum_q <= sum_q - size_q;
              if (rdata.size == size_q) begin
                k_q     <= idx_q;
                state_q <= ST_DN_RD;
              end else begin
                we_q         <= 1'b1;
                waddr_q      <= idx_q[IDX_W-1:0];
                wdata_q.addr <= rdata.addr + size_q;
                wdata_q.size <= rdata.size - size_q;
                state_q      <= ST_DONE;
              end
            end else begin
              idx_q   <= idx_inc;
              state_q <= (idx_inc == count_q) ? ST_DONE : ST_RD;
            end
          end else if (rdata.addr > addr_q) begin
            nxt_q      <= rdata;
            has_next_q <= 1'b1;
            state_q    <= ST_DEC;
          end else begin
            prev_q     <= rdata;
            has_prev_q <= 1'b1;
            idx_q      <= idx_inc;
            state_q    <= (idx_inc == count_q) ? ST_DEC : ST_RD;
          end
        end
        ST_DEC: begin
          if (prev_touch) begin
            sum_q        <= sum_q + size_q;
            we_q         <= 1'b1;
            waddr_q      <= IDX_W'(idx_q - CNT_W'(1));
            wdata_q.addr <= prev_q.addr;
            if (next_touch) begin
              wdata_q.size <= prev_q.size + size_q + nxt_q.size;
              k_q          <= idx_q;
              state_q      <= ST_DN_RD;
            end else begin
              wdata_q.size <= prev_q.size + size_q;
              state_q      <= ST_DONE;
            end
          end else if (next_touch) begin
            sum_q        <= sum_q + size_q;
            we_q         <= 1'b1;
            waddr_q      <= idx_q[IDX_W-1:0];
            wdata_q.addr <= addr_q;
            wdata_q.size <= nxt_q.size + size_q;
            state_q      <= ST_DONE;
          end else if (count_q < CNT_W'(MAX_SEG)) begin
            sum_q   <= sum_q + size_q;
            k_q     <= count_q;
            state_q <= ST_UP_RD;
          end else begin
            lost_n_q <= lost_n_q + 32'd1;
            lost_b_q <= lost_b_q + size_q;
            failed_q <= 1'b1;
            state_q  <= ST_DONE;
          end
        end
        ST_DN_RD: begin
          if ((k_q + CNT_W'(1)) < count_q) begin
            state_q <= ST_DN_WR;
          end else begin
            count_q <= count_q - CNT_W'(1);
            state_q <= ST_DONE;
          end
        end
        ST_DN_WR: begin
          we_q    <= 1'b1;
          waddr_q <= k_q[IDX_W-1:0];
          wdata_q <= rdata;
          k_q     <= k_q + CNT_W'(1);
          state_q <= ST_DN_RD;
        end
        ST_UP_RD: begin
          if (k_q > idx_q) begin
            state_q <= ST_UP_WR;
          end else begin
            we_q         <= 1'b1;
            waddr_q      <= idx_q[IDX_W-1:0];
            wdata_q.addr <= addr_q;
            wdata_q.size <= size_q;
            count_q      <= count_q + CNT_W'(1);
            if (peak_q < (count_q + CNT_W'(1))) begin
              peak_q <= count_q + CNT_W'(1);
            end
            state_q <= ST_DONE;
          end
        end
        ST_UP_WR: begin
          we_q    <= 1'b1;
          waddr_q <= k_q[IDX_W-1:0];
          wdata_q <= rdata;
          k_q     <= k_q - CNT_W'(1);
          state_q <= ST_UP_RD;
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= failed_q;
            m_axis_tdata  <= {2'b00, lost_b_q, lost_n_q, ENTRY_W'(peak_q),
                              ENTRY_W'(count_q), sum_q, got_q};
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

@@ src/ffl_checker.sv @@
// Port-level checks for the first-fit free-list allocator, bound to the top.
// Depends on ffl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ffl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);
  `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output word dropped")
  `ASSERT_CLK(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "accepted while busy")
  `ASSERT_CLK(a_count_le_peak, m_axis_tvalid |-> (m_axis_tdata[74:64] <= m_axis_tdata[85:75]), "count above peak")
  `ASSERT_CLK(a_fail_no_addr, m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[31:0] == 32'd0), "failed free with address")
endmodule

bind first_fit_free_list_allocator ffl_checker u_ffl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
